// ----- rtl/abr_pkg.sv -----
// Shared types and constants for the affine bilinear resampler.
// Transaction payload structs, register indexes and reset values; no dependencies.
`timescale 1ns / 1ps

package abr_pkg;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_RENDER = 1'b1;

	localparam int REG_IDX_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_COEF_XX    = 3'd0,
		REG_COEF_YX    = 3'd1,
		REG_COEF_XY    = 3'd2,
		REG_COEF_YY    = 3'd3,
		REG_OFFSET_X   = 3'd4,
		REG_OFFSET_Y   = 3'd5,
		REG_CLEAR_RGBA = 3'd6,
		REG_SRC_EXTENT = 3'd7
	} reg_idx_t;

	localparam logic [31:0] RST_COEF_XX    = 32'h0001_0000;
	localparam logic [31:0] RST_COEF_YX    = 32'h0000_0000;
	localparam logic [31:0] RST_COEF_XY    = 32'h0000_0000;
	localparam logic [31:0] RST_COEF_YY    = 32'h0001_0000;
	localparam logic [31:0] RST_OFFSET_X   = 32'h0000_0000;
	localparam logic [31:0] RST_OFFSET_Y   = 32'h0000_0000;
	localparam logic [31:0] RST_CLEAR_RGBA = 32'h0000_0000;
	localparam logic [31:0] RST_SRC_EXTENT = 32'h0080_0080;

	typedef struct packed {
		logic               opcode;
		logic [6:0]         load_x;
		logic [6:0]         load_y;
		logic [31:0]        load_rgba;
		logic signed [15:0] dest_x;
		logic signed [15:0] dest_y;
	} in_item_t;

	typedef struct packed {
		logic [31:0]        out_rgba;
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
	} out_item_t;

	typedef struct packed {
		logic [31:0] coef_xx;
		logic [31:0] coef_yx;
		logic [31:0] coef_xy;
		logic [31:0] coef_yy;
		logic [31:0] offset_x;
		logic [31:0] offset_y;
		logic [31:0] clear_rgba;
		logic [31:0] src_extent;
	} cfg_t;

	// Per-stage neighbor info from the store stage to the blend stage.
	typedef struct packed {
		logic x_in0;
		logic x_in1;
		logic y_in0;
		logic y_in1;
		logic x_odd;
		logic y_odd;
	} nbr_ctl_t;

endpackage

// ----- rtl/abr_map.sv -----
// Affine coordinate map: four coefficient products, then the Q-format sums.
// Uses abr_pkg for the configuration struct.
`timescale 1ns / 1ps

module abr_map #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                advance,
	input  logic signed [15:0]  dest_x,
	input  logic signed [15:0]  dest_y,
	input  abr_pkg::cfg_t       cfg,
	output logic signed [49:0]  sx_s2,
	output logic signed [49:0]  sy_s2
);

	localparam logic signed [50:0] HALF = 51'sd1 <<< FRAC_BITS;

	logic signed [16:0] cx;
	logic signed [16:0] cy;
	logic signed [48:0] p_xx_s1, p_xy_s1, p_yx_s1, p_yy_s1;
	logic signed [50:0] off_x2, off_y2;
	logic signed [50:0] sum_x, sum_y;

	// pixel centre doubled: 2*d + 1
	assign cx = {dest_x, 1'b1};
	assign cy = {dest_y, 1'b1};

	always_ff @(posedge clk) begin
		if (advance) begin
			p_xx_s1 <= $signed(cfg.coef_xx) * cx;
			p_xy_s1 <= $signed(cfg.coef_xy) * cy;
			p_yx_s1 <= $signed(cfg.coef_yx) * cx;
			p_yy_s1 <= $signed(cfg.coef_yy) * cy;
		end
	end

	assign off_x2 = {{18{cfg.offset_x[31]}}, cfg.offset_x, 1'b0};
	assign off_y2 = {{18{cfg.offset_y[31]}}, cfg.offset_y, 1'b0};
	assign sum_x  = 51'(p_xx_s1) + 51'(p_xy_s1) + off_x2 - HALF;
	assign sum_y  = 51'(p_yx_s1) + 51'(p_yy_s1) + off_y2 - HALF;

	always_ff @(posedge clk) begin
		if (advance) begin
			sx_s2 <= sum_x[50:1];
			sy_s2 <= sum_y[50:1];
		end
	end

endmodule

// ----- rtl/abr_store.sv -----
// Source image store in four banks split by column and row parity, so the four
// neighbors are read together. Uses abr_pkg for the neighbor info struct.
`timescale 1ns / 1ps

module abr_store #(
	parameter int FRAC_BITS      = 16,
	parameter int SRC_MAX_WIDTH  = 128,
	parameter int SRC_MAX_HEIGHT = 128
) (
	input  logic                  clk,
	input  logic                  advance,
	input  logic                  wr_en,
	input  logic [6:0]            load_x,
	input  logic [6:0]            load_y,
	input  logic [31:0]           load_rgba,
	input  logic signed [49:0]    sx,
	input  logic signed [49:0]    sy,
	input  logic [31:0]           src_extent,
	output logic [3:0][31:0]      pix_s3,
	output abr_pkg::nbr_ctl_t     nbr_s3,
	output logic [FRAC_BITS-1:0]  fx_s3,
	output logic [FRAC_BITS-1:0]  fy_s3
);

	localparam int CW    = 50 - FRAC_BITS;
	localparam int XH    = (SRC_MAX_WIDTH + 1) / 2;
	localparam int YH    = (SRC_MAX_HEIGHT + 1) / 2;
	localparam int DEPTH = XH * YH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0]  XH_A  = AW'(XH);
	localparam logic [15:0]    MAX_W = 16'(SRC_MAX_WIDTH);
	localparam logic [15:0]    MAX_H = 16'(SRC_MAX_HEIGHT);

	logic signed [CW-1:0] x0, x1, y0, y1, w_ext, h_ext;
	logic [15:0]          w_sat, h_sat;
	logic [1:0][AW-1:0]   col, row;
	logic [3:0][AW-1:0]   raddr;
	logic [AW-1:0]        waddr;
	logic [1:0]           wbank;
	logic                 load_ok;
	abr_pkg::nbr_ctl_t    nbr;

	assign x0 = sx[49:FRAC_BITS];
	assign y0 = sy[49:FRAC_BITS];
	assign x1 = x0 + CW'(1);
	assign y1 = y0 + CW'(1);

	// saturate the extent to the store size
	assign w_sat = (src_extent[15:0]  > MAX_W) ? MAX_W : src_extent[15:0];
	assign h_sat = (src_extent[31:16] > MAX_H) ? MAX_H : src_extent[31:16];
	assign w_ext = {{(CW-16){1'b0}}, w_sat};
	assign h_ext = {{(CW-16){1'b0}}, h_sat};

	assign nbr.x_in0 = !x0[CW-1] && (x0 < w_ext);
	assign nbr.x_in1 = !x1[CW-1] && (x1 < w_ext);
	assign nbr.y_in0 = !y0[CW-1] && (y0 < h_ext);
	assign nbr.y_in1 = !y1[CW-1] && (y1 < h_ext);
	assign nbr.x_odd = x0[0];
	assign nbr.y_odd = y0[0];

	// even bank holds x0 when x0 is even, else x0+1
	assign col[1] = x0[AW:1];
	assign col[0] = x0[AW:1] + AW'(x0[0]);
	assign row[1] = y0[AW:1];
	assign row[0] = y0[AW:1] + AW'(y0[0]);

	always_comb begin
		for (int b = 0; b < 4; b++) begin
			raddr[b] = row[b / 2] * XH_A + col[b % 2];
		end
	end

	assign load_ok = ({25'd0, load_x} < 32'(SRC_MAX_WIDTH))
		&& ({25'd0, load_y} < 32'(SRC_MAX_HEIGHT));
	assign waddr   = AW'(load_y[6:1]) * XH_A + AW'(load_x[6:1]);
	assign wbank   = {load_y[0], load_x[0]};

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [31:0] mem [DEPTH];

		always_ff @(posedge clk) begin
			if (advance) begin
				if (wr_en && load_ok && (wbank == 2'(b))) begin
					mem[waddr] <= load_rgba;
				end
				pix_s3[b] <= mem[raddr[b]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			nbr_s3 <= nbr;
			fx_s3  <= sx[FRAC_BITS-1:0];
			fy_s3  <= sy[FRAC_BITS-1:0];
		end
	end

endmodule

// ----- rtl/abr_blend.sv -----
// Bilinear blend: horizontal weighting of each neighbor row, then vertical.
// Uses abr_pkg for the neighbor info struct.
`timescale 1ns / 1ps

module abr_blend #(
	parameter int FRAC_BITS = 16,
	parameter int CHANNELS  = 4
) (
	input  logic                 clk,
	input  logic                 advance,
	input  logic [3:0][31:0]     pix_s3,
	input  abr_pkg::nbr_ctl_t    nbr_s3,
	input  logic [FRAC_BITS-1:0] fx_s3,
	input  logic [FRAC_BITS-1:0] fy_s3,
	input  logic [31:0]          clear_rgba,
	output logic [31:0]          rgba_s5
);

	localparam int WW = FRAC_BITS + 1;
	localparam int HW = FRAC_BITS + 10;
	localparam int AW = 2 * FRAC_BITS + 12;
	localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;

	logic [3:0][31:0]  nbr_px;
	logic [WW-1:0]     wx0, wx1, wy0, wy1;
	logic [WW-1:0]     wy0_s4, wy1_s4;
	logic [CHANNELS-1:0][7:0] byte_s5;

	assign wx1 = {1'b0, fx_s3};
	assign wx0 = ONE - wx1;
	assign wy1 = {1'b0, fy_s3};
	assign wy0 = ONE - wy1;

	// neighbor k: row k/2, column k%2; bank picked by parity, clear when outside
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			logic r, c, nbr_in;
			r      = k[1];
			c      = k[0];
			nbr_in = (r ? nbr_s3.y_in1 : nbr_s3.y_in0) && (c ? nbr_s3.x_in1 : nbr_s3.x_in0);
			nbr_px[k] = nbr_in ? pix_s3[{nbr_s3.y_odd ^ r, nbr_s3.x_odd ^ c}] : clear_rgba;
		end
	end

	for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_ch
		localparam int SH = 8 * (3 - ch);
		logic [1:0][HW-1:0] h_s4;
		logic [AW-1:0] acc;

		always_ff @(posedge clk) begin
			if (advance) begin
				h_s4[0] <= HW'(wx0) * HW'(nbr_px[0][SH +: 8])
					+ HW'(wx1) * HW'(nbr_px[1][SH +: 8]);
				h_s4[1] <= HW'(wx0) * HW'(nbr_px[2][SH +: 8])
					+ HW'(wx1) * HW'(nbr_px[3][SH +: 8]);
			end
		end

		assign acc = AW'(wy0_s4) * AW'(h_s4[0]) + AW'(wy1_s4) * AW'(h_s4[1]);

		always_ff @(posedge clk) begin
			if (advance) begin
				byte_s5[ch] <= acc[2*FRAC_BITS +: 8];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			wy0_s4 <= wy0;
			wy1_s4 <= wy1;
		end
	end

	always_comb begin
		rgba_s5 = '0;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			rgba_s5[8*(3-ch) +: 8] = byte_s5[ch];
		end
	end

endmodule

// ----- rtl/affine_bilinear_resampler.sv -----
// Top level of the affine bilinear resampler: configuration registers,
// transaction pipeline control. Uses abr_pkg, abr_map, abr_store, abr_blend.
`timescale 1ns / 1ps

// One transaction enters per clock; the whole pipeline holds while a
// result waits at the output. A rendered pixel passes registers for the
// affine products, affine sums, source read, horizontal blend and vertical
// blend. The four neighbors come from four memory banks split by column
// and row parity, each read once per cycle, setting the one-pixel-per-clock
// rate. Loads write the store in order with renders and give no result.
// The user must write configuration only when idle; nothing enforces it.
module affine_bilinear_resampler #(
	parameter int CHANNELS       = 4,
	parameter int SRC_MAX_WIDTH  = 128,
	parameter int SRC_MAX_HEIGHT = 128,
	parameter int FRAC_BITS      = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  abr_pkg::in_item_t                  in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output abr_pkg::out_item_t                 out_data,
	input  logic                               cfg_we,
	input  logic [abr_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [31:0]                        cfg_wdata
);

	abr_pkg::cfg_t       cfg_q;
	logic                advance;
	logic                v_s1, v_s2;
	logic                rv_s3, rv_s4, rv_s5;
	abr_pkg::in_item_t   item_s1, item_s2;
	logic signed [15:0]  dx_s3, dx_s4, dx_s5, dy_s3, dy_s4, dy_s5;
	logic signed [49:0]  sx_s2, sy_s2;
	logic [3:0][31:0]    pix_s3;
	abr_pkg::nbr_ctl_t   nbr_s3;
	logic [FRAC_BITS-1:0] fx_s3, fy_s3;
	logic [31:0]         rgba_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coef_xx    <= abr_pkg::RST_COEF_XX;
			cfg_q.coef_yx    <= abr_pkg::RST_COEF_YX;
			cfg_q.coef_xy    <= abr_pkg::RST_COEF_XY;
			cfg_q.coef_yy    <= abr_pkg::RST_COEF_YY;
			cfg_q.offset_x   <= abr_pkg::RST_OFFSET_X;
			cfg_q.offset_y   <= abr_pkg::RST_OFFSET_Y;
			cfg_q.clear_rgba <= abr_pkg::RST_CLEAR_RGBA;
			cfg_q.src_extent <= abr_pkg::RST_SRC_EXTENT;
		end else if (cfg_we) begin
			case (abr_pkg::reg_idx_t'(cfg_index))
				abr_pkg::REG_COEF_XX:    cfg_q.coef_xx    <= cfg_wdata;
				abr_pkg::REG_COEF_YX:    cfg_q.coef_yx    <= cfg_wdata;
				abr_pkg::REG_COEF_XY:    cfg_q.coef_xy    <= cfg_wdata;
				abr_pkg::REG_COEF_YY:    cfg_q.coef_yy    <= cfg_wdata;
				abr_pkg::REG_OFFSET_X:   cfg_q.offset_x   <= cfg_wdata;
				abr_pkg::REG_OFFSET_Y:   cfg_q.offset_y   <= cfg_wdata;
				abr_pkg::REG_CLEAR_RGBA: cfg_q.clear_rgba <= cfg_wdata;
				abr_pkg::REG_SRC_EXTENT: cfg_q.src_extent <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// hold every stage while the output transaction waits
	assign advance  = !out_valid || out_ready;
	assign in_ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			rv_s3 <= 1'b0;
			rv_s4 <= 1'b0;
			rv_s5 <= 1'b0;
		end else if (advance) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			rv_s3 <= v_s2 && (item_s2.opcode == abr_pkg::OP_RENDER);
			rv_s4 <= rv_s3;
			rv_s5 <= rv_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s1 <= in_data;
			item_s2 <= item_s1;
			dx_s3   <= item_s2.dest_x;
			dy_s3   <= item_s2.dest_y;
			dx_s4   <= dx_s3;
			dy_s4   <= dy_s3;
			dx_s5   <= dx_s4;
			dy_s5   <= dy_s4;
		end
	end

	abr_map #(
		.FRAC_BITS(FRAC_BITS)
	) u_map (
		.clk     (clk),
		.advance (advance),
		.dest_x  (in_data.dest_x),
		.dest_y  (in_data.dest_y),
		.cfg     (cfg_q),
		.sx_s2   (sx_s2),
		.sy_s2   (sy_s2)
	);

	abr_store #(
		.FRAC_BITS      (FRAC_BITS),
		.SRC_MAX_WIDTH  (SRC_MAX_WIDTH),
		.SRC_MAX_HEIGHT (SRC_MAX_HEIGHT)
	) u_store (
		.clk        (clk),
		.advance    (advance),
		.wr_en      (v_s2 && (item_s2.opcode == abr_pkg::OP_LOAD)),
		.load_x     (item_s2.load_x),
		.load_y     (item_s2.load_y),
		.load_rgba  (item_s2.load_rgba),
		.sx         (sx_s2),
		.sy         (sy_s2),
		.src_extent (cfg_q.src_extent),
		.pix_s3     (pix_s3),
		.nbr_s3     (nbr_s3),
		.fx_s3      (fx_s3),
		.fy_s3      (fy_s3)
	);

	abr_blend #(
		.FRAC_BITS (FRAC_BITS),
		.CHANNELS  (CHANNELS)
	) u_blend (
		.clk        (clk),
		.advance    (advance),
		.pix_s3     (pix_s3),
		.nbr_s3     (nbr_s3),
		.fx_s3      (fx_s3),
		.fy_s3      (fy_s3),
		.clear_rgba (cfg_q.clear_rgba),
		.rgba_s5    (rgba_s5)
	);

	assign out_valid         = rv_s5;
	assign out_data.out_rgba = rgba_s5;
	assign out_data.out_x    = dx_s5;
	assign out_data.out_y    = dy_s5;

endmodule
